// File: hw/rtl/vtu_pkg.sv
// shared types and constants of the vertex transform unit
package vtu_pkg;

    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam int OP_W      = 2;
    localparam int NUM_LANES = 9;
    localparam int NUM_COMP  = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_POINT  = 2'd0;
    localparam logic [OP_W-1:0] OP_NORMAL = 2'd1;
    localparam logic [OP_W-1:0] OP_QROT   = 2'd2;
    localparam logic [OP_W-1:0] OP_PASS   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_XY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1Z_ROW2X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_YZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_XY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3Z_TX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_YZ    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_XY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_ZW     = 3'd7;

    // identity matrix and identity quaternion, 1.0 = 65536
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t m11;
        word_t m12;
        word_t m13;
        word_t m21;
        word_t m22;
        word_t m23;
        word_t m31;
        word_t m32;
        word_t m33;
        word_t tx;
        word_t ty;
        word_t tz;
        word_t qx;
        word_t qy;
        word_t qz;
        word_t qw;
    } coef_t;

endpackage

// File: hw/rtl/vtu_core.sv
// six-stage transform datapath: matrix and quaternion paths sharing the first multiplier bank
module vtu_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vtu_pkg::coef_t               coef,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [vtu_pkg::OP_W-1:0]     s_opcode,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_x,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_y,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_x,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_y,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_z,
    output logic                         m_saturated
);

    localparam int W      = vtu_pkg::WORD_W;
    localparam int TW     = vtu_pkg::PROD_W - FRAC_BITS;
    localparam int SW     = TW + 2;
    localparam int NL     = vtu_pkg::NUM_LANES;
    localparam int NC     = vtu_pkg::NUM_COMP;
    localparam int STAGES = 6;

    typedef logic signed [W-1:0]              word_t;
    typedef logic signed [vtu_pkg::PROD_W-1:0] full_t;
    typedef logic signed [TW-1:0]             trunc_t;
    typedef logic signed [SW-1:0]             sum_t;
    typedef logic [vtu_pkg::OP_W-1:0]         op_t;

    function automatic logic sat_ovf(input sum_t v);
        return !((&v[SW-1:W-1]) || !(|v[SW-1:W-1]));
    endfunction

    function automatic word_t sat_val(input sum_t v);
        word_t r;
        if (sat_ovf(v)) begin
            r = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // stage valid bits, index STAGES-1 is the output register
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld_in;

    // stage 1: input register
    op_t    op1_reg;
    word_t  vec1_reg [NC];
    // stage 2: first products
    op_t    op2_reg;
    word_t  vec2_reg [NC];
    trunc_t prod2_reg [NL];
    // stage 3: matrix sums, rotation intermediate
    op_t    op3_reg;
    word_t  vec3_reg [NC];
    sum_t   sum3_reg [NC];
    word_t  t3_reg [NC];
    logic   flag3_reg;
    // stage 4: second products
    op_t    op4_reg;
    word_t  vec4_reg [NC];
    sum_t   sum4_reg [NC];
    trunc_t prod4_reg [NL];
    logic   flag4_reg;
    // stage 5: final sums
    sum_t   sum5_reg [NC];
    logic   flag5_reg;
    // stage 6: output
    word_t  out_reg [NC];
    logic   sat_reg;

    word_t  a_op [NL];
    word_t  b_op [NL];
    full_t  full2 [NL];
    trunc_t prod2_next [NL];
    word_t  trans [NC];
    sum_t   sum3_next [NC];
    word_t  t3_next [NC];
    sum_t   tq [NC];
    logic   flag3_next;
    word_t  c_op [NL];
    word_t  d_op [NL];
    full_t  full4 [NL];
    trunc_t prod4_next [NL];
    sum_t   sum5_next [NC];
    word_t  out_next [NC];
    logic   sat_next;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_in = {vld_reg[STAGES-2:0], s_valid};
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // first multiplier bank: matrix rows or q x v
    always_comb begin
        if (op1_reg == vtu_pkg::OP_QROT) begin
            a_op[0] = coef.qy; b_op[0] = vec1_reg[2];
            a_op[1] = coef.qz; b_op[1] = vec1_reg[1];
            a_op[2] = coef.qz; b_op[2] = vec1_reg[0];
            a_op[3] = coef.qx; b_op[3] = vec1_reg[2];
            a_op[4] = coef.qx; b_op[4] = vec1_reg[1];
            a_op[5] = coef.qy; b_op[5] = vec1_reg[0];
            a_op[6] = '0;      b_op[6] = '0;
            a_op[7] = '0;      b_op[7] = '0;
            a_op[8] = '0;      b_op[8] = '0;
        end else begin
            a_op[0] = vec1_reg[0]; b_op[0] = coef.m11;
            a_op[1] = vec1_reg[1]; b_op[1] = coef.m21;
            a_op[2] = vec1_reg[2]; b_op[2] = coef.m31;
            a_op[3] = vec1_reg[0]; b_op[3] = coef.m12;
            a_op[4] = vec1_reg[1]; b_op[4] = coef.m22;
            a_op[5] = vec1_reg[2]; b_op[5] = coef.m32;
            a_op[6] = vec1_reg[0]; b_op[6] = coef.m13;
            a_op[7] = vec1_reg[1]; b_op[7] = coef.m23;
            a_op[8] = vec1_reg[2]; b_op[8] = coef.m33;
        end
        for (int i = 0; i < NL; i++) begin
            full2[i]      = a_op[i] * b_op[i];
            prod2_next[i] = full2[i][vtu_pkg::PROD_W-1:FRAC_BITS];
        end
    end

    // matrix row sums and t = 2 (q x v)
    always_comb begin
        trans[0] = coef.tx;
        trans[1] = coef.ty;
        trans[2] = coef.tz;
        flag3_next = 1'b0;
        for (int c = 0; c < NC; c++) begin
            sum3_next[c] = SW'(prod2_reg[3*c]) + SW'(prod2_reg[3*c+1])
                         + SW'(prod2_reg[3*c+2])
                         + ((op2_reg == vtu_pkg::OP_POINT) ? SW'(trans[c]) : sum_t'(0));
            tq[c] = (SW'(prod2_reg[2*c]) - SW'(prod2_reg[2*c+1])) <<< 1;
            t3_next[c] = sat_val(tq[c]);
            if (op2_reg == vtu_pkg::OP_QROT && sat_ovf(tq[c])) begin
                flag3_next = 1'b1;
            end
        end
    end

    // second multiplier bank: w*t and q x t
    always_comb begin
        c_op[0] = t3_reg[0]; d_op[0] = coef.qw;
        c_op[1] = coef.qy;   d_op[1] = t3_reg[2];
        c_op[2] = coef.qz;   d_op[2] = t3_reg[1];
        c_op[3] = t3_reg[1]; d_op[3] = coef.qw;
        c_op[4] = coef.qz;   d_op[4] = t3_reg[0];
        c_op[5] = coef.qx;   d_op[5] = t3_reg[2];
        c_op[6] = t3_reg[2]; d_op[6] = coef.qw;
        c_op[7] = coef.qx;   d_op[7] = t3_reg[1];
        c_op[8] = coef.qy;   d_op[8] = t3_reg[0];
        for (int i = 0; i < NL; i++) begin
            full4[i]      = c_op[i] * d_op[i];
            prod4_next[i] = full4[i][vtu_pkg::PROD_W-1:FRAC_BITS];
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            case (op4_reg)
                vtu_pkg::OP_POINT,
                vtu_pkg::OP_NORMAL: begin
                    sum5_next[c] = sum4_reg[c];
                end
                vtu_pkg::OP_QROT: begin
                    sum5_next[c] = SW'(vec4_reg[c]) + SW'(prod4_reg[3*c])
                                 + (SW'(prod4_reg[3*c+1]) - SW'(prod4_reg[3*c+2]));
                end
                default: begin
                    sum5_next[c] = SW'(vec4_reg[c]);
                end
            endcase
        end
    end

    always_comb begin
        sat_next = flag5_reg;
        for (int c = 0; c < NC; c++) begin
            out_next[c] = sat_val(sum5_reg[c]);
            if (sat_ovf(sum5_reg[c])) begin
                sat_next = 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (en[0] && vld_in[0]) begin
            op1_reg     <= s_opcode;
            vec1_reg[0] <= s_in_x;
            vec1_reg[1] <= s_in_y;
            vec1_reg[2] <= s_in_z;
        end
        if (en[1] && vld_in[1]) begin
            op2_reg   <= op1_reg;
            vec2_reg  <= vec1_reg;
            prod2_reg <= prod2_next;
        end
        if (en[2] && vld_in[2]) begin
            op3_reg   <= op2_reg;
            vec3_reg  <= vec2_reg;
            sum3_reg  <= sum3_next;
            t3_reg    <= t3_next;
            flag3_reg <= flag3_next;
        end
        if (en[3] && vld_in[3]) begin
            op4_reg   <= op3_reg;
            vec4_reg  <= vec3_reg;
            sum4_reg  <= sum3_reg;
            prod4_reg <= prod4_next;
            flag4_reg <= flag3_reg;
        end
        if (en[4] && vld_in[4]) begin
            sum5_reg  <= sum5_next;
            flag5_reg <= flag4_reg;
        end
        if (en[5] && vld_in[5]) begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid     = vld_reg[STAGES-1];
    assign m_out_x     = out_reg[0];
    assign m_out_y     = out_reg[1];
    assign m_out_z     = out_reg[2];
    assign m_saturated = sat_reg;

endmodule

// File: hw/rtl/vertex_transform_unit.sv
// vertex transform unit: configuration registers around the transform pipeline
// an accepted input transaction passes the six register stages (input, products, sums,
// products, sums, saturate/output) before m_valid offers its result
// throughput: one transaction per cycle; a stall holds each full stage in place
// reset clears all stage valid bits and loads the identity matrix and quaternion
module vertex_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [vtu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtu_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vtu_pkg::OP_W-1:0]          s_opcode,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_x,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_y,
    input  logic signed [vtu_pkg::WORD_W-1:0] s_in_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_x,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_y,
    output logic signed [vtu_pkg::WORD_W-1:0] m_out_z,
    output logic                              m_saturated
);

    localparam int W = vtu_pkg::WORD_W;

    logic [vtu_pkg::CFG_W-1:0] cfg_reg [vtu_pkg::NUM_REGS];
    vtu_pkg::coef_t            coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vtu_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= vtu_pkg::CFG_RESET[i];
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // unpack the coefficient pairs, low half first
    always_comb begin
        coef.m11 = cfg_reg[vtu_pkg::REG_ROW1_XY][W-1:0];
        coef.m12 = cfg_reg[vtu_pkg::REG_ROW1_XY][2*W-1:W];
        coef.m13 = cfg_reg[vtu_pkg::REG_ROW1Z_ROW2X][W-1:0];
        coef.m21 = cfg_reg[vtu_pkg::REG_ROW1Z_ROW2X][2*W-1:W];
        coef.m22 = cfg_reg[vtu_pkg::REG_ROW2_YZ][W-1:0];
        coef.m23 = cfg_reg[vtu_pkg::REG_ROW2_YZ][2*W-1:W];
        coef.m31 = cfg_reg[vtu_pkg::REG_ROW3_XY][W-1:0];
        coef.m32 = cfg_reg[vtu_pkg::REG_ROW3_XY][2*W-1:W];
        coef.m33 = cfg_reg[vtu_pkg::REG_ROW3Z_TX][W-1:0];
        coef.tx  = cfg_reg[vtu_pkg::REG_ROW3Z_TX][2*W-1:W];
        coef.ty  = cfg_reg[vtu_pkg::REG_TRANS_YZ][W-1:0];
        coef.tz  = cfg_reg[vtu_pkg::REG_TRANS_YZ][2*W-1:W];
        coef.qx  = cfg_reg[vtu_pkg::REG_QUAT_XY][W-1:0];
        coef.qy  = cfg_reg[vtu_pkg::REG_QUAT_XY][2*W-1:W];
        coef.qz  = cfg_reg[vtu_pkg::REG_QUAT_ZW][W-1:0];
        coef.qw  = cfg_reg[vtu_pkg::REG_QUAT_ZW][2*W-1:W];
    end

    vtu_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .coef        (coef),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_in_x      (s_in_x),
        .s_in_y      (s_in_y),
        .s_in_z      (s_in_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_saturated (m_saturated)
    );

endmodule

// File: test/vertex_transform_unit_tb.sv
// self-checking testbench for the vertex transform unit
module vertex_transform_unit_tb;

    localparam int FRAC_BITS       = 16;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 12;
    localparam bit LO              = 1'b0;
    localparam bit HI              = 1'b1;

    typedef enum int {COEF_SMALL, COEF_FULL, COEF_EXTREME, COEF_MIXED} coef_mode_t;

    typedef logic [vtu_pkg::CFG_W-1:0] reg_file_t [vtu_pkg::NUM_REGS];
    typedef logic [vtu_pkg::OP_W-1:0]  op_t;

    typedef struct packed {
        vtu_pkg::word_t x;
        vtu_pkg::word_t y;
        vtu_pkg::word_t z;
        logic           sat;
    } vec_res_t;

    typedef struct {
        bit                            is_cfg;
        logic [vtu_pkg::CFG_IDX_W-1:0] idx;
        logic [vtu_pkg::CFG_W-1:0]     data;
        op_t                           op;
        vtu_pkg::word_t                x;
        vtu_pkg::word_t                y;
        vtu_pkg::word_t                z;
        bit                            has_lit;
        vec_res_t                      lit;
    } stim_row_t;

    localparam coef_mode_t PHASE_MODE [NUM_PHASES] = '{
        COEF_SMALL, COEF_FULL, COEF_EXTREME, COEF_MIXED,
        COEF_SMALL, COEF_MIXED, COEF_FULL, COEF_SMALL
    };

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [vtu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vtu_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    op_t                           s_opcode;
    vtu_pkg::word_t                s_in_x;
    vtu_pkg::word_t                s_in_y;
    vtu_pkg::word_t                s_in_z;
    logic                          m_valid;
    logic                          m_ready;
    vtu_pkg::word_t                m_out_x;
    vtu_pkg::word_t                m_out_y;
    vtu_pkg::word_t                m_out_z;
    logic                          m_saturated;

    // typed-in expectation travels with the transaction it belongs to
    logic                 exp_lit_use;
    vec_res_t             exp_lit;

    reg_file_t            reg_shadow;
    vec_res_t             pending_vertices [$];
    int                   fail_count = 0;
    int                   cycle_count = 0;
    bit                   steady = 1'b0;

    vertex_transform_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_in_x      (s_in_x),
        .s_in_y      (s_in_y),
        .s_in_z      (s_in_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clip32(longint v, inout bit clipped);
        if (v > 64'sh7FFF_FFFF) begin
            clipped = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clipped = 1'b1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic longint coef(int idx, bit upper);
        logic [vtu_pkg::CFG_W-1:0] w;
        w = reg_shadow[idx];
        return upper ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    function automatic vec_res_t transform_vertex(op_t op, vtu_pkg::word_t x,
                                                  vtu_pkg::word_t y, vtu_pkg::word_t z);
        longint vx, vy, vz, rx, ry, rz, tx, ty, tz, qx, qy, qz, qw;
        bit clipped;
        vec_res_t r;
        clipped = 1'b0;
        vx = x;
        vy = y;
        vz = z;
        case (op)
            vtu_pkg::OP_POINT, vtu_pkg::OP_NORMAL: begin
                // row vector times matrix
                rx = fx_mul(vx, coef(vtu_pkg::REG_ROW1_XY, LO))
                   + fx_mul(vy, coef(vtu_pkg::REG_ROW1Z_ROW2X, HI))
                   + fx_mul(vz, coef(vtu_pkg::REG_ROW3_XY, LO));
                ry = fx_mul(vx, coef(vtu_pkg::REG_ROW1_XY, HI))
                   + fx_mul(vy, coef(vtu_pkg::REG_ROW2_YZ, LO))
                   + fx_mul(vz, coef(vtu_pkg::REG_ROW3_XY, HI));
                rz = fx_mul(vx, coef(vtu_pkg::REG_ROW1Z_ROW2X, LO))
                   + fx_mul(vy, coef(vtu_pkg::REG_ROW2_YZ, HI))
                   + fx_mul(vz, coef(vtu_pkg::REG_ROW3Z_TX, LO));
                if (op == vtu_pkg::OP_POINT) begin
                    rx += coef(vtu_pkg::REG_ROW3Z_TX, HI);
                    ry += coef(vtu_pkg::REG_TRANS_YZ, LO);
                    rz += coef(vtu_pkg::REG_TRANS_YZ, HI);
                end
            end
            vtu_pkg::OP_QROT: begin
                qx = coef(vtu_pkg::REG_QUAT_XY, LO);
                qy = coef(vtu_pkg::REG_QUAT_XY, HI);
                qz = coef(vtu_pkg::REG_QUAT_ZW, LO);
                qw = coef(vtu_pkg::REG_QUAT_ZW, HI);
                // t = 2(q x v), clipped before the second stage
                tx = clip32(2 * (fx_mul(qy, vz) - fx_mul(qz, vy)), clipped);
                ty = clip32(2 * (fx_mul(qz, vx) - fx_mul(qx, vz)), clipped);
                tz = clip32(2 * (fx_mul(qx, vy) - fx_mul(qy, vx)), clipped);
                rx = vx + fx_mul(tx, qw) + (fx_mul(qy, tz) - fx_mul(qz, ty));
                ry = vy + fx_mul(ty, qw) + (fx_mul(qz, tx) - fx_mul(qx, tz));
                rz = vz + fx_mul(tz, qw) + (fx_mul(qx, ty) - fx_mul(qy, tx));
            end
            default: begin
                rx = vx;
                ry = vy;
                rz = vz;
            end
        endcase
        if (op != vtu_pkg::OP_PASS) begin
            rx = clip32(rx, clipped);
            ry = clip32(ry, clipped);
            rz = clip32(rz, clipped);
        end
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.z = rz[31:0];
        r.sat = clipped;
        return r;
    endfunction

    function automatic vtu_pkg::word_t extreme_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_FFFF;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic vtu_pkg::word_t rand_coef(coef_mode_t mode);
        coef_mode_t k;
        k = mode;
        if (k == COEF_MIXED)
            k = coef_mode_t'($urandom_range(0, 2));
        case (k)
            COEF_SMALL: return int'($urandom_range(0, 262144)) - 131072;
            COEF_FULL: return $urandom;
            default: return extreme_word();
        endcase
    endfunction

    function automatic vtu_pkg::word_t rand_component();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        if (pick < 85)
            return $urandom;
        return extreme_word();
    endfunction

    function automatic op_t rand_opcode();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return vtu_pkg::OP_POINT;
        if (pick < 6)
            return vtu_pkg::OP_NORMAL;
        if (pick < 9)
            return vtu_pkg::OP_QROT;
        return vtu_pkg::OP_PASS;
    endfunction

    function automatic stim_row_t vec_row(op_t op, vtu_pkg::word_t x, vtu_pkg::word_t y,
                                          vtu_pkg::word_t z);
        stim_row_t r;
        r = '{default: '0};
        r.op = op;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic stim_row_t lit_row(op_t op, vtu_pkg::word_t x, vtu_pkg::word_t y,
                                          vtu_pkg::word_t z, vtu_pkg::word_t ex,
                                          vtu_pkg::word_t ey, vtu_pkg::word_t ez,
                                          logic es);
        stim_row_t r;
        r = vec_row(op, x, y, z);
        r.has_lit = 1'b1;
        r.lit = '{ex, ey, ez, es};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [vtu_pkg::CFG_IDX_W-1:0] idx,
                                          logic [vtu_pkg::CFG_W-1:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic push_item(op_t op, vtu_pkg::word_t x, vtu_pkg::word_t y,
                             vtu_pkg::word_t z, bit has_lit, vec_res_t lit);
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_in_x <= x;
        s_in_y <= y;
        s_in_z <= z;
        exp_lit_use <= has_lit;
        exp_lit <= lit;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_vertices.size() != 0);
    endtask

    task automatic load_regs(reg_file_t vals);
        wait_for_results();
        for (int i = 0; i < vtu_pkg::NUM_REGS; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= vtu_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            reg_shadow[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    // receiver stalls
    always @(posedge aclk)
        m_ready <= steady || ($urandom_range(0, 99) >= 16);

    always @(posedge aclk) begin
        vec_res_t got;
        vec_res_t want;
        if (aresetn && s_valid && s_ready)
            pending_vertices.push_back(exp_lit_use ? exp_lit
                                     : transform_vertex(s_opcode, s_in_x, s_in_y, s_in_z));
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_x, m_out_y, m_out_z, m_saturated};
            if (pending_vertices.size() == 0) begin
                if (fail_count < 10)
                    $display("result with nothing outstanding: x=%h y=%h z=%h sat=%b",
                             got.x, got.y, got.z, got.sat);
                fail_count++;
            end else begin
                want = pending_vertices.pop_front();
                if (got !== want) begin
                    if (fail_count < 10)
                        $display("mismatch: expected %h %h %h sat=%b, got %h %h %h sat=%b",
                                 want.x, want.y, want.z, want.sat,
                                 got.x, got.y, got.z, got.sat);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[vertex_transform_unit] ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t directed [$];
        stim_row_t row;
        reg_file_t vals;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_opcode <= vtu_pkg::OP_POINT;
        s_in_x <= '0;
        s_in_y <= '0;
        s_in_z <= '0;
        exp_lit_use <= 1'b0;
        exp_lit <= '0;

        // identity after reset: vectors pass through
        directed.push_back(lit_row(vtu_pkg::OP_POINT,
                                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0));
        directed.push_back(lit_row(vtu_pkg::OP_NORMAL, 32'hFFFE_8000, 32'h0000_8000, 32'h0,
                                   32'hFFFE_8000, 32'h0000_8000, 32'h0, 1'b0));
        directed.push_back(lit_row(vtu_pkg::OP_QROT,
                                   32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                                   32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0));
        directed.push_back(lit_row(vtu_pkg::OP_PASS,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(lit_row(vtu_pkg::OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
        directed.push_back(lit_row(vtu_pkg::OP_QROT,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        // largest translation: point clips, normal ignores it
        directed.push_back(cfg_row(vtu_pkg::REG_ROW3Z_TX, 64'h7FFF_FFFF_0001_0000));
        directed.push_back(lit_row(vtu_pkg::OP_POINT, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1));
        directed.push_back(lit_row(vtu_pkg::OP_NORMAL, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0));
        directed.push_back(cfg_row(vtu_pkg::REG_ROW1_XY, 64'h0002_0000_7FFF_FFFF));
        directed.push_back(lit_row(vtu_pkg::OP_NORMAL, 32'h0001_0000, 32'h0, 32'h0,
                                   32'h7FFF_FFFF, 32'h0002_0000, 32'h0, 1'b0));
        directed.push_back(vec_row(vtu_pkg::OP_NORMAL, 32'h8000_0000, 32'h0, 32'h0));
        // asymmetric matrix so that row and column order differ
        directed.push_back(cfg_row(vtu_pkg::REG_ROW1Z_ROW2X, 64'h0003_0000_FFFF_0000));
        directed.push_back(cfg_row(vtu_pkg::REG_ROW2_YZ, 64'h8000_0000_0000_8000));
        directed.push_back(cfg_row(vtu_pkg::REG_ROW3_XY, 64'h1234_5678_FFFF_8000));
        directed.push_back(cfg_row(vtu_pkg::REG_TRANS_YZ, 64'h8000_0000_0001_0000));
        directed.push_back(vec_row(vtu_pkg::OP_POINT,
                                   32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000));
        directed.push_back(vec_row(vtu_pkg::OP_NORMAL,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(vec_row(vtu_pkg::OP_POINT,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // large quaternion: the cross product clips in the first stage
        directed.push_back(cfg_row(vtu_pkg::REG_QUAT_XY, 64'h7FFF_FFFF_0000_8000));
        directed.push_back(cfg_row(vtu_pkg::REG_QUAT_ZW, 64'h0000_B505_8000_0000));
        directed.push_back(vec_row(vtu_pkg::OP_QROT, 32'h0, 32'h0, 32'h7FFF_FFFF));
        directed.push_back(vec_row(vtu_pkg::OP_QROT,
                                   32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000));
        directed.push_back(lit_row(vtu_pkg::OP_PASS, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0,
                                   32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 1'b0));
        directed.push_back(vec_row(vtu_pkg::OP_QROT,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        reg_shadow = vtu_pkg::CFG_RESET;

        foreach (directed[i]) begin
            row = directed[i];
            if (row.is_cfg) begin
                vals = reg_shadow;
                vals[row.idx] = row.data;
                load_regs(vals);
            end else begin
                push_item(row.op, row.x, row.y, row.z, row.has_lit, row.lit);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int r = 0; r < vtu_pkg::NUM_REGS; r++)
                vals[r] = {rand_coef(PHASE_MODE[p]), rand_coef(PHASE_MODE[p])};
            load_regs(vals);
            // one phase runs back to back on both sides
            steady = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_item(rand_opcode(), rand_component(), rand_component(), rand_component(),
                          1'b0, '0);
        end
        steady = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_vertices.size() == 0)
            $display("[vertex_transform_unit] OK");
        else
            $display("[vertex_transform_unit] ERROR");
        $finish;
    end

endmodule
